[rtl/lwpc_pkg.sv]
// Shared types, constants and lookup functions for the window/pixel command stream unit.
`default_nettype none

package lwpc_pkg;

   // Panel command bytes.
   localparam logic [7:0] CMD_COL_SET = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET = 8'h2B;
   localparam logic [7:0] CMD_MEM_WR  = 8'h2C;

   // Opcodes of a request.
   localparam logic OP_WINDOW = 1'b0;
   localparam logic OP_PIXEL  = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_ROTATION = 1'b0;
   localparam logic CSR_READY    = 1'b1;

   localparam int CSR_DATA_W = 2;

   // Job queue between the front and the back end (power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Byte steps of a window job; the last step sends the memory-write command.
   localparam logic [3:0] WIN_LAST_STEP = 4'd10;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  x_pos;
      logic [7:0]  y_pos;
      logic [7:0]  win_width;
      logic [7:0]  win_height;
      logic [15:0] pixel_color;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       rejected;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_PIXEL  = 2'd0,
      JOB_WINDOW = 2'd1,
      JOB_REJECT = 2'd2
   } job_kind_type;

   // For a window job data holds {xs, xe, ys, ye}; for a pixel job the
   // colour sits in the low half.
   typedef struct packed {
      job_kind_type kind;
      logic [31:0]  data;
   } job_type;

   function automatic logic [7:0] scr_width(input logic [1:0] rot);
      return rot[0] ? 8'd160 : 8'd128;
   endfunction

   function automatic logic [7:0] scr_height(input logic [1:0] rot);
      return rot[0] ? 8'd128 : 8'd160;
   endfunction

   function automatic logic [7:0] col_offset(input logic [1:0] rot);
      return rot[0] ? 8'd1 : 8'd2;
   endfunction

   function automatic logic [7:0] row_offset(input logic [1:0] rot);
      return rot[0] ? 8'd2 : 8'd1;
   endfunction

endpackage

`default_nettype wire

[rtl/lcd_window_pixel_command_stream_unit.sv]
// A request accepted into the job queue is registered there; the back end then loads its
// first byte into the result register. It emits one byte per cycle while a job is queued
// and results are popped: a pixel gives 2 bytes, a window 11 and a rejected window 1.
// A four-entry job queue lets requests be accepted while earlier bytes are still going out.
// Reset (synchronous, active high) empties the queue and the result register and
// clears rotation and ready to zero.
`default_nettype none

module lcd_window_pixel_command_stream_unit (
   input  wire                    clock,
   input  wire                    reset,
   // Request side, queue-like: accepted when push is high and full is low.
   input  wire                    req_push,
   output logic                   req_full,
   input  wire lwpc_pkg::req_type req_data,
   // Result side: the oldest byte is shown while empty is low.
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output lwpc_pkg::rsp_type      rsp_data,
   // Configuration write port.
   input  wire                    csr_write_en,
   input  wire                    csr_index,
   input  wire [lwpc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lwpc_pkg::*;

   logic [1:0] rotation_ff;
   logic       ready_ff;
   job_type    front_job;
   job_type    head_job;
   logic       queue_full;
   logic       queue_not_empty;
   logic       job_done;
   logic       rsp_valid;

   // The user must write the configuration registers only while the unit is idle; the block
   // does not enforce it. So the front end may read them directly when it classifies a request.
   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= 2'd0;
         ready_ff    <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROTATION: rotation_ff <= csr_wdata[1:0];
            CSR_READY:    ready_ff    <= csr_wdata[0];
         endcase
      end
   end

   // The front end checks the request and precomputes the window words, so the
   // back end only has to pick bytes.
   lwpc_front u_front (
      .req       (req_data),
      .rotation  (rotation_ff),
      .ready_cfg (ready_ff),
      .job       (front_job)
   );

   lwpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_job  (front_job),
      .full      (queue_full),
      .pop       (job_done),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   // The back end retires a job from the queue when it loads the job's last byte
   // into the result register.
   lwpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job       (head_job),
      .job_done  (job_done),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data),
      .rsp_take  (rsp_pop)
   );

   assign req_full  = queue_full;
   assign rsp_empty = !rsp_valid;

endmodule

`default_nettype wire

[rtl/lwpc_front.sv]
// Front end: checks a request and turns it into a compact job for the queue.
`default_nettype none

module lwpc_front (
   input  wire  lwpc_pkg::req_type req,
   input  wire  [1:0]              rotation,
   input  wire                     ready_cfg,
   output lwpc_pkg::job_type       job
);
   import lwpc_pkg::*;

   logic [8:0] x_end;
   logic [8:0] y_end;
   logic       fits;
   logic [7:0] xs;
   logic [7:0] xe;
   logic [7:0] ys;
   logic [7:0] ye;

   always_comb begin
      x_end = {1'b0, req.x_pos} + {1'b0, req.win_width};
      y_end = {1'b0, req.y_pos} + {1'b0, req.win_height};
      fits  = ready_cfg && (req.win_width != 8'd0) && (req.win_height != 8'd0) &&
              (x_end <= {1'b0, scr_width(rotation)}) &&
              (y_end <= {1'b0, scr_height(rotation)});

      // Only meaningful when the window fits; then every value stays below 256.
      xs = req.x_pos + col_offset(rotation);
      xe = xs + req.win_width - 8'd1;
      ys = req.y_pos + row_offset(rotation);
      ye = ys + req.win_height - 8'd1;

      if (req.opcode == OP_PIXEL) begin
         job.kind = JOB_PIXEL;
         job.data = {16'd0, req.pixel_color};
      end else if (fits) begin
         job.kind = JOB_WINDOW;
         job.data = {xs, xe, ys, ye};
      end else begin
         job.kind = JOB_REJECT;
         job.data = 32'd0;
      end
   end

endmodule

`default_nettype wire

[rtl/lwpc_queue.sv]
// Small register queue of jobs between the front and the back end.
`default_nettype none

module lwpc_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire lwpc_pkg::job_type push_job,
   output logic                   full,
   input  wire                    pop,
   output logic                   not_empty,
   output lwpc_pkg::job_type      head_job
);
   import lwpc_pkg::*;

   job_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff;
   logic [QUEUE_AW:0]     count_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head_job  = entry_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      // Pointers wrap on their own since the depth is a power of two.
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/lwpc_back.sv]
// Back end: steps through the bytes of the head job into the result register.
`default_nettype none

module lwpc_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    job_valid,
   input  wire lwpc_pkg::job_type job,
   output logic                   job_done,
   output logic                   rsp_valid,
   output lwpc_pkg::rsp_type      rsp,
   input  wire                    rsp_take
);
   import lwpc_pkg::*;

   logic [3:0] step_ff;
   logic [3:0] step_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   rsp_type    out_ff;
   rsp_type    out_in;
   rsp_type    cur;
   logic       advance;

   // Byte produced by the current job at the current step.
   always_comb begin
      cur = '{out_byte: 8'd0, is_data: 1'b1, rejected: 1'b0, last: 1'b0};
      unique case (job.kind)
         JOB_PIXEL: begin
            cur.out_byte = (step_ff == 4'd0) ? job.data[15:8] : job.data[7:0];
            cur.last     = (step_ff != 4'd0);
         end
         JOB_WINDOW: begin
            unique case (step_ff)
               4'd0:    begin cur.out_byte = CMD_COL_SET; cur.is_data = 1'b0; end
               4'd2:    cur.out_byte = job.data[31:24];
               4'd4:    cur.out_byte = job.data[23:16];
               4'd5:    begin cur.out_byte = CMD_ROW_SET; cur.is_data = 1'b0; end
               4'd7:    cur.out_byte = job.data[15:8];
               4'd9:    cur.out_byte = job.data[7:0];
               4'd10: begin
                  cur.out_byte = CMD_MEM_WR;
                  cur.is_data  = 1'b0;
                  cur.last     = 1'b1;
               end
               default: cur.out_byte = 8'd0;   // high bytes of the words
            endcase
         end
         default: begin
            cur.is_data  = 1'b0;
            cur.rejected = 1'b1;
            cur.last     = 1'b1;
         end
      endcase
   end

   always_comb begin
      advance      = job_valid && (!out_valid_ff || rsp_take);
      job_done     = advance && cur.last;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_in       = cur;
         out_valid_in = 1'b1;
         step_in      = cur.last ? 4'd0 : step_ff + 4'd1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
      rsp_valid = out_valid_ff;
      rsp       = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

[rtl/lwpc_checker.sv]
// Port-level checks of the command stream unit and the bind that attaches them.
`default_nettype none

module lwpc_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_full,
   input wire                    rsp_empty,
   input wire                    rsp_pop,
   input wire lwpc_pkg::rsp_type rsp_data
);
   import lwpc_pkg::*;

   // Reset leaves no result waiting and room for requests.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("unit not empty after reset");

   // A rejected window is a single plain result.
   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.rejected) |->
         (rsp_data.last && !rsp_data.is_data && rsp_data.out_byte == 8'd0))
      else $error("malformed rejected result");

   // Command bytes are the three panel commands, and only memory-write ends a window.
   a_command_bytes: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.is_data && !rsp_data.rejected) |->
         ((rsp_data.out_byte == CMD_COL_SET || rsp_data.out_byte == CMD_ROW_SET ||
           rsp_data.out_byte == CMD_MEM_WR) &&
          (rsp_data.last == (rsp_data.out_byte == CMD_MEM_WR))))
      else $error("unexpected command byte");

   // A waiting result that is not popped stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");

endmodule

bind lcd_window_pixel_command_stream_unit lwpc_checker u_checker (.*);

`default_nettype wire

[test/lwpc_stream_checker.sv]
// Checker for the window/pixel command stream unit: predicts the byte stream and compares it.
`default_nettype none

module lwpc_stream_checker (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   input  wire                 req_full,
   input  lwpc_pkg::req_type   req_data,
   input  wire                 rsp_empty,
   input  wire                 rsp_pop,
   input  lwpc_pkg::rsp_type   rsp_data,
   input  wire                 csr_write_en,
   input  wire                 csr_index,
   input  wire [lwpc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                  fail_count,
   output int                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import lwpc_pkg::*;

   // Local copy of the two registers, tracked from the write port.
   logic [1:0] rot_copy = 2'd0;
   logic       ready_copy = 1'b0;

   // Panel bytes still owed by the block, oldest first.
   rsp_type    owed_bytes[$];

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic owe_byte(input logic [7:0] value, input logic dc, input logic rej,
                           input logic fin);
      rsp_type b;
      b.out_byte = value;
      b.is_data  = dc;
      b.rejected = rej;
      b.last     = fin;
      owed_bytes.push_back(b);
   endtask

   task automatic owe_word_pair(input logic [15:0] first, input logic [15:0] second);
      owe_byte(first[15:8], 1'b1, 1'b0, 1'b0);
      owe_byte(first[7:0], 1'b1, 1'b0, 1'b0);
      owe_byte(second[15:8], 1'b1, 1'b0, 1'b0);
      owe_byte(second[7:0], 1'b1, 1'b0, 1'b0);
   endtask

   // Works out every byte one request produces under the current registers.
   task automatic predict_request(input req_type r);
      logic [8:0]  x_end, y_end, scr_w, scr_h;
      logic [15:0] col_lo, col_hi, row_lo, row_hi;
      if (r.opcode == OP_PIXEL) begin
         owe_byte(r.pixel_color[15:8], 1'b1, 1'b0, 1'b0);
         owe_byte(r.pixel_color[7:0], 1'b1, 1'b0, 1'b1);
         return;
      end
      // Odd rotations turn the panel to landscape.
      scr_w = rot_copy[0] ? 9'd160 : 9'd128;
      scr_h = rot_copy[0] ? 9'd128 : 9'd160;
      x_end = {1'b0, r.x_pos} + {1'b0, r.win_width};
      y_end = {1'b0, r.y_pos} + {1'b0, r.win_height};
      if (!ready_copy || r.win_width == 8'd0 || r.win_height == 8'd0 ||
          x_end > scr_w || y_end > scr_h) begin
         owe_byte(8'd0, 1'b0, 1'b1, 1'b1);
         return;
      end
      col_lo = 16'(r.x_pos) + (rot_copy[0] ? 16'd1 : 16'd2);
      col_hi = col_lo + 16'(r.win_width) - 16'd1;
      row_lo = 16'(r.y_pos) + (rot_copy[0] ? 16'd2 : 16'd1);
      row_hi = row_lo + 16'(r.win_height) - 16'd1;
      owe_byte(CMD_COL_SET, 1'b0, 1'b0, 1'b0);
      owe_word_pair(col_lo, col_hi);
      owe_byte(CMD_ROW_SET, 1'b0, 1'b0, 1'b0);
      owe_word_pair(row_lo, row_hi);
      owe_byte(CMD_MEM_WR, 1'b0, 1'b0, 1'b1);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         owed_bytes.delete();
         rot_copy = 2'd0;
         ready_copy = 1'b0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_ROTATION) begin
               rot_copy = csr_wdata[1:0];
            end else if (csr_index == CSR_READY) begin
               ready_copy = csr_wdata[0];
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (owed_bytes.size() == 0) begin
               report_mismatch("unexpected result", int'(rsp_data), 0);
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
               if (rsp_data.is_data !== want.is_data)
                  report_mismatch("is_data", rsp_data.is_data, want.is_data);
               if (rsp_data.rejected !== want.rejected)
                  report_mismatch("rejected", rsp_data.rejected, want.rejected);
               if (rsp_data.last !== want.last)
                  report_mismatch("last", rsp_data.last, want.last);
            end
         end
         if (req_push && !req_full) begin
            predict_request(req_data);
         end
      end
      pending_count <= owed_bytes.size();
   end

endmodule

`default_nettype wire

[test/lcd_window_pixel_command_stream_unit_tb.sv]
// Testbench top for the window/pixel command stream unit: stimulus, handshakes and verdict.
`default_nettype none

module lcd_window_pixel_command_stream_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lwpc_pkg::*;

   // Every block input holds a known value from time zero; reset starts high.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   req_type    req_data = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_en = 1'b0;
   logic       csr_index = CSR_ROTATION;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int         fail_count;
   int         pending_count;

   // Chance, in percent, that the sender idles before a request and that
   // the receiver holds off popping in a given cycle.
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;

   // Rotation last written, used only to shape windows that fit the screen.
   logic [1:0] cur_rotation = 2'd0;

   lcd_window_pixel_command_stream_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   lwpc_stream_checker stream_check (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver decides at each falling edge whether to pop in the next cycle.
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // The whole run must finish well within this time, even with heavy stalls.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // A window request; the colour field is ignored by the block, so it is random.
   function automatic req_type make_window(input int x, input int y, input int w,
                                           input int h);
      req_type r;
      r.opcode      = OP_WINDOW;
      r.x_pos       = 8'(x);
      r.y_pos       = 8'(y);
      r.win_width   = 8'(w);
      r.win_height  = 8'(h);
      r.pixel_color = 16'($urandom);
      return r;
   endfunction

   // A pixel request; the window fields are ignored, so they carry random junk.
   function automatic req_type make_pixel(input logic [15:0] color);
      req_type r;
      r.opcode      = OP_PIXEL;
      r.x_pos       = 8'($urandom);
      r.y_pos       = 8'($urandom);
      r.win_width   = 8'($urandom);
      r.win_height  = 8'($urandom);
      r.pixel_color = color;
      return r;
   endfunction

   // Offers one request and returns at the falling edge after it was taken.
   // Push stays high between back-to-back requests, and is only lowered in
   // idle cycles, so it never gets two assignments in one step.
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // Stops pushing and waits until every predicted byte has come out, then
   // waits on further falling edges so the byte sequencer is surely idle.
   task automatic drain_block();
      req_push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // One register write, held for a single cycle; the enable is low again before the task returns.
   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      if (idx == CSR_ROTATION) begin
         cur_rotation = value[1:0];
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Random traffic: mostly pixels and windows that fit the current screen,
   // some windows that overhang by exactly one pixel, and some pure noise.
   task automatic send_random_item();
      int      pick, sw, sh, w, h;
      req_type noise;
      pick = $urandom_range(99);
      sw = cur_rotation[0] ? 160 : 128;
      sh = cur_rotation[0] ? 128 : 160;
      w = $urandom_range(sw, 1);
      h = $urandom_range(sh, 1);
      if (pick < 45) begin
         send_request(make_pixel(16'($urandom)));
      end else if (pick < 86) begin
         send_request(make_window($urandom_range(sw - w), $urandom_range(sh - h), w, h));
      end else if (pick < 93) begin
         if ($urandom_range(1) == 1) begin
            send_request(make_window(sw - w + 1, $urandom_range(sh - h), w, h));
         end else begin
            send_request(make_window($urandom_range(sw - w), sh - h + 1, w, h));
         end
      end else begin
         noise.opcode      = 1'($urandom);
         noise.x_pos       = 8'($urandom);
         noise.y_pos       = 8'($urandom);
         noise.win_width   = 8'($urandom);
         noise.win_height  = 8'($urandom);
         noise.pixel_color = 16'($urandom);
         send_request(noise);
      end
   endtask

   initial begin
      req_type odd_pixel;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Straight after reset the panel is not ready: pixels still go out,
      // but any window must be rejected.
      send_request(make_pixel(16'h0000));
      send_request(make_pixel(16'hFFFF));
      send_request(make_window(0, 0, 1, 1));
      drain_block();

      // Portrait, ready: full screen, empty sizes, one-pixel overhangs,
      // all-ones fields and the bottom-right corner pixel.
      write_csr(CSR_READY, 2'b01);
      write_csr(CSR_ROTATION, 2'd0);
      send_request(make_window(0, 0, 128, 160));
      send_request(make_window(0, 0, 0, 10));
      send_request(make_window(0, 0, 10, 0));
      send_request(make_window(1, 0, 128, 1));
      send_request(make_window(0, 1, 1, 160));
      send_request(make_window(255, 255, 255, 255));
      send_request(make_window(127, 159, 1, 1));
      // A pixel whose window fields are all ones must ignore them.
      odd_pixel.opcode      = OP_PIXEL;
      odd_pixel.x_pos       = 8'hFF;
      odd_pixel.y_pos       = 8'hFF;
      odd_pixel.win_width   = 8'hFF;
      odd_pixel.win_height  = 8'hFF;
      odd_pixel.pixel_color = 16'hA5C3;
      send_request(odd_pixel);
      drain_block();

      // Landscape: the portrait full screen no longer fits.
      write_csr(CSR_ROTATION, 2'd1);
      send_request(make_window(0, 0, 160, 128));
      send_request(make_window(0, 0, 128, 160));
      send_request(make_window(159, 127, 1, 1));
      send_request(make_pixel(16'h1234));
      drain_block();

      write_csr(CSR_ROTATION, 2'd3);
      send_request(make_window(0, 0, 160, 128));
      send_request(make_window(10, 20, 150, 108));
      drain_block();

      write_csr(CSR_ROTATION, 2'd2);
      send_request(make_window(0, 0, 128, 160));
      send_request(make_window(0, 0, 160, 128));
      send_request(make_window(5, 7, 3, 4));
      drain_block();

      // Ready dropped again, with the unused upper data bit set.
      write_csr(CSR_READY, 2'b10);
      send_request(make_pixel(16'h8001));
      send_request(make_window(0, 0, 1, 1));
      drain_block();

      // Random segments: each idling phase is run under two rotations, and
      // one segment runs with the panel not ready.
      for (int seg = 0; seg < 8; seg++) begin
         case (seg / 2)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 71;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 71;
            end
            default: begin
               sender_idle_pct = 7;
               receiver_stall_pct = 7;
            end
         endcase
         write_csr(CSR_ROTATION, 2'(seg % 4));
         write_csr(CSR_READY, {1'($urandom), (seg != 6)});
         repeat (55) send_random_item();
         drain_block();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
